// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the timed event list RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/tel_pkg.sv -----
// ----------------------------------------------------------------------------
// tel_pkg
// Types and constants shared by the timed event list modules.
// ----------------------------------------------------------------------------
package tel_pkg;

   localparam int MODE_W = 3;
   localparam int STAT_W = 2;
   localparam int ID_W   = 8;
   localparam int TIME_W = 32;

   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ADJUST = 3'd2;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_HANDLE = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOMATCH = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd3;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_CHECK,
      S_SCAN
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] evt_time;
   } slot_entry_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] evt_time;
   } rsp_type;

endpackage

// ----- sv/tel_mem.sv -----
// ----------------------------------------------------------------------------
// tel_mem
// Slot table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tel_mem
   import tel_pkg::*;
#(
   parameter int LIST_DEPTH = 512
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(LIST_DEPTH)-1:0] wr_addr,
   input  slot_entry_type                wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(LIST_DEPTH)-1:0] rd_addr,
   output slot_entry_type                rd_data
);

   slot_entry_type mem [LIST_DEPTH];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/tel_scan.sv -----
// ----------------------------------------------------------------------------
// tel_scan
// Sequencer: clears the table, then walks it one slot a cycle per request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tel_scan
   import tel_pkg::*;
#(
   parameter int LIST_DEPTH = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [MODE_W-1:0]             mode,
   input  logic [ID_W-1:0]               event_id,
   input  logic [TIME_W-1:0]             event_time,
   output logic                          busy,
   output logic                          mem_wr_en,
   output logic [$clog2(LIST_DEPTH)-1:0] mem_wr_addr,
   output slot_entry_type                mem_wr_data,
   output logic                          mem_rd_en,
   output logic [$clog2(LIST_DEPTH)-1:0] mem_rd_addr,
   input  slot_entry_type                mem_rd_data,
   output logic                          done,
   output rsp_type                       rsp
);

   localparam int AW = $clog2(LIST_DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(LIST_DEPTH - 1);

   state_type         state_ff, state_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              issued_all_ff, issued_all_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_idx_ff, pend_idx_in;
   logic              best_found_ff, best_found_in;
   logic [AW-1:0]     best_idx_ff, best_idx_in;
   logic [ID_W-1:0]   best_id_ff, best_id_in;
   logic [TIME_W-1:0] best_time_ff, best_time_in;
   logic [AW-1:0]     next_slot_ff, next_slot_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic [ID_W-1:0]   hit_id_ff, hit_id_in;

   logic              accept, unused_mode, issue, last_proc, hit;
   logic              scan_end, stale, clear_end, finish, cand;
   logic              fin_found;
   logic [AW-1:0]     fin_idx;
   logic [ID_W-1:0]   fin_id;
   logic [TIME_W-1:0] fin_time;
   logic [TIME_W-1:0] sat_time;

   // Decisions shared by the next-state, output and datapath logic
   always_comb begin
      accept      = start && (state_ff == S_IDLE);
      unused_mode = !(mode inside {[MODE_INSERT:MODE_HANDLE]});
      issue       = (state_ff == S_SCAN) && !issued_all_ff;
      last_proc   = pend_ff && (pend_idx_ff == LAST_IDX);
      hit = pend_ff &&
            (((mode_ff == MODE_INSERT) && !mem_rd_data.valid) ||
             (((mode_ff == MODE_REMOVE) || (mode_ff == MODE_ADJUST)) &&
              mem_rd_data.valid && (mem_rd_data.id == id_ff)));
      scan_end  = (state_ff == S_SCAN) && (hit || last_proc);
      stale     = (state_ff == S_CHECK) && !mem_rd_data.valid;
      clear_end = (state_ff == S_CLEAR) && (idx_ff == LAST_IDX);
      finish    = scan_end || stale || (accept && unused_mode);
      cand = pend_ff && (mode_ff == MODE_QUERY) && mem_rd_data.valid &&
             (!best_found_ff || (mem_rd_data.evt_time < best_time_ff));
      fin_found = best_found_ff || cand;
      fin_idx   = cand ? pend_idx_ff : best_idx_ff;
      fin_id    = cand ? mem_rd_data.id : best_id_ff;
      fin_time  = cand ? mem_rd_data.evt_time : best_time_ff;
      sat_time  = (mem_rd_data.evt_time > elapsed_ff) ?
                  (mem_rd_data.evt_time - elapsed_ff) : '0;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clear_end) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept && !unused_mode) begin
               state_in = (mode == MODE_HANDLE) ? S_FETCH : S_SCAN;
            end
         end
         S_FETCH: state_in = S_CHECK;
         S_CHECK: state_in = mem_rd_data.valid ? S_SCAN : S_IDLE;
         S_SCAN: begin
            if (scan_end) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Outputs: memory controls and the result
   always_comb begin
      busy        = (state_ff != S_IDLE);
      mem_wr_en   = 1'b0;
      mem_wr_addr = pend_idx_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx_ff;
      done        = finish;
      rsp         = '{status: STAT_OK, id: '0, evt_time: '0};
      case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff;
            mem_wr_data = '{valid: 1'b0, id: '0, evt_time: '0};
         end
         S_FETCH: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = next_slot_ff;
         end
         S_CHECK: begin
            if (stale) begin
               rsp.status = STAT_EMPTY;
            end
         end
         S_SCAN: begin
            mem_rd_en = issue;
            if (hit) begin
               mem_wr_en = 1'b1;
               case (mode_ff)
                  MODE_INSERT: mem_wr_data = '{valid: 1'b1, id: id_ff, evt_time: time_ff};
                  MODE_REMOVE: mem_wr_data.valid = 1'b0;
                  default:     mem_wr_data.evt_time = time_ff;
               endcase
            end else if (pend_ff && (mode_ff == MODE_HANDLE) && mem_rd_data.valid) begin
               mem_wr_en            = 1'b1;
               mem_wr_data.valid    = (pend_idx_ff != next_slot_ff);
               mem_wr_data.evt_time = sat_time;
            end
            case (mode_ff)
               MODE_INSERT: rsp.status = hit ? STAT_OK : STAT_FULL;
               MODE_REMOVE,
               MODE_ADJUST: rsp.status = hit ? STAT_OK : STAT_NOMATCH;
               MODE_QUERY: begin
                  if (fin_found) begin
                     rsp = '{status: STAT_OK, id: fin_id, evt_time: fin_time};
                  end else begin
                     rsp.status = STAT_EMPTY;
                  end
               end
               MODE_HANDLE: rsp = '{status: STAT_OK, id: hit_id_ff, evt_time: elapsed_ff};
               default: rsp.status = STAT_OK;
            endcase
         end
         default: rsp.status = STAT_OK;
      endcase
   end

   // Datapath registers
   always_comb begin
      mode_in       = mode_ff;
      id_in         = id_ff;
      time_in       = time_ff;
      idx_in        = idx_ff;
      issued_all_in = issued_all_ff;
      pend_in       = issue && !scan_end;
      pend_idx_in   = idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_id_in    = best_id_ff;
      best_time_in  = best_time_ff;
      next_slot_in  = next_slot_ff;
      elapsed_in    = elapsed_ff;
      hit_id_in     = hit_id_ff;
      case (state_ff)
         S_CLEAR: idx_in = clear_end ? '0 : idx_ff + AW'(1);
         S_IDLE: begin
            if (accept) begin
               mode_in       = mode;
               id_in         = event_id;
               time_in       = event_time;
               idx_in        = '0;
               issued_all_in = 1'b0;
               best_found_in = 1'b0;
            end
         end
         S_CHECK: begin
            elapsed_in = mem_rd_data.evt_time;
            hit_id_in  = mem_rd_data.id;
         end
         S_SCAN: begin
            if (issue) begin
               if (idx_ff == LAST_IDX) begin
                  issued_all_in = 1'b1;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
            if (cand) begin
               best_found_in = 1'b1;
               best_idx_in   = pend_idx_ff;
               best_id_in    = mem_rd_data.id;
               best_time_in  = mem_rd_data.evt_time;
            end
            // remember the winner once the walk is over
            if (scan_end && (mode_ff == MODE_QUERY) && fin_found) begin
               next_slot_in = fin_idx;
            end
         end
         default: idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         idx_ff        <= '0;
         issued_all_ff <= 1'b0;
         pend_ff       <= 1'b0;
         best_found_ff <= 1'b0;
         next_slot_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         issued_all_ff <= issued_all_in;
         pend_ff       <= pend_in;
         best_found_ff <= best_found_in;
         next_slot_ff  <= next_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      id_ff        <= id_in;
      time_ff      <= time_in;
      pend_idx_ff  <= pend_idx_in;
      best_idx_ff  <= best_idx_in;
      best_id_ff   <= best_id_in;
      best_time_ff <= best_time_in;
      elapsed_ff   <= elapsed_in;
      hit_id_ff    <= hit_id_in;
   end

   `ASSERT_IMPL(a_no_rw_collision, clock, reset, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "write and read hit the same slot")
   `ASSERT_NEXT(a_done_to_idle, clock, reset, done, state_ff == S_IDLE, "sequencer not idle after result")
   `ASSERT_IMPL(a_pend_in_scan, clock, reset, pend_ff, state_ff == S_SCAN, "read data pending outside walk")
   `ASSERT_IMPL(a_full_from_insert, clock, reset, done && (rsp.status == STAT_FULL), mode_ff == MODE_INSERT, "full status from non-insert")
   `ASSERT_IMPL(a_fired_slot_freed, clock, reset, mem_wr_en && (state_ff == S_SCAN) && (mode_ff == MODE_HANDLE) && (mem_wr_addr == next_slot_ff), !mem_wr_data.valid, "fired slot left valid")

endmodule

// ----- sv/timed_event_list.sv -----
// ----------------------------------------------------------------------------
// timed_event_list
// Table of pending timed events with insert, remove, adjust, query and handle.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: drive req_mode, req_event_id and req_event_time with start
//   high; the request is taken at a clock edge where start is high and busy is
//   low. busy stays high until the request has finished (unused modes never raise it).
//   Response channel: every request yields exactly one response, shown on
//   rsp_status, rsp_result_id and rsp_result_time for one cycle with
//   rsp_strobe high. The receiver cannot hold it off.
//   Completion: query walks the whole table; handle first fetches and checks
//   the remembered slot, ends there when it is already free and otherwise
//   walks the whole table; insert/remove/adjust stop at the slot that matched
//   (or walk the whole table if none did); unused modes finish at once.
//   Throughput is set by the slot table's single read port: the sequencer
//   reads one slot per cycle and writes back the slot read the cycle before.
//   After reset busy stays high while every slot is marked free; requests
//   are taken once that clearing pass is over.
// ----------------------------------------------------------------------------
module timed_event_list
   import tel_pkg::*;
#(
   parameter int LIST_DEPTH = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [ID_W-1:0]   req_event_id,
   input  logic [TIME_W-1:0] req_event_time,
   output logic              rsp_strobe,
   output logic [STAT_W-1:0] rsp_status,
   output logic [ID_W-1:0]   rsp_result_id,
   output logic [TIME_W-1:0] rsp_result_time
);

   localparam int AW = $clog2(LIST_DEPTH);

   logic           mem_wr_en, mem_rd_en;
   logic [AW-1:0]  mem_wr_addr, mem_rd_addr;
   slot_entry_type mem_wr_data, mem_rd_data;
   logic           done;
   rsp_type        rsp;

   logic           rsp_strobe_ff, rsp_strobe_in;
   rsp_type        rsp_ff, rsp_in;

   // Sequencer: clearing pass, request decode and the slot walk
   tel_scan #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .mode        (req_mode),
      .event_id    (req_event_id),
      .event_time  (req_event_time),
      .busy        (busy),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .done        (done),
      .rsp         (rsp)
   );

   // Slot table holding valid flag, id and remaining time
   tel_mem #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Register the response with a one-cycle strobe; capture only when a request completes
   always_comb begin
      rsp_strobe_in = done;
      rsp_in        = done ? rsp : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_result_id   = rsp_ff.id;
   assign rsp_result_time = rsp_ff.evt_time;

endmodule
